/* src/bspline_weight_generator_top_assert.svh */
// Assertion macros for the B-spline weight generator checker.
// They use the clk and rst_n names of the module that expands them.
`ifndef BSPLINE_WEIGHT_GENERATOR_TOP_ASSERT_SVH
`define BSPLINE_WEIGHT_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define BSWG_AST_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bswg check failed");

// next-cycle implication, off during reset
`define BSWG_AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bswg check failed");

// what must hold in the cycle after reset is seen
`define BSWG_AST_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("bswg reset check failed");

`endif

/* src/bswg_pkg.sv */
package bswg_pkg;

  localparam int FRAC_BITS = 16;

  localparam int XW    = FRAC_BITS;          // position
  localparam int WW    = FRAC_BITS + 1;      // weight, Q1.F; also 1-x
  localparam int X2W   = 2 * FRAC_BITS;      // x^2
  localparam int T2W   = 2 * FRAC_BITS + 1;  // y^2, d^2 (up to 2^2F)
  localparam int X3W   = 3 * FRAC_BITS;      // x^3
  localparam int T3W   = 3 * FRAC_BITS + 1;  // y^3 (up to 2^3F)
  localparam int ACCW  = 3 * FRAC_BITS + 4;  // cubic inner numerator
  localparam int QW    = FRAC_BITS + 3;      // numerator / 2^2F, before /6
  localparam int VW    = FRAC_BITS + 2;      // half of that, before /3
  localparam int DIV3_SH = FRAC_BITS + 3;
  localparam int PW    = 2 * VW;

  localparam int ORDER_W = 2;
  localparam int LANES   = 4;

  localparam int IN_TDATA_W  = ((XW + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((LANES * WW + 7) / 8) * 8;

  localparam logic [WW-1:0]   WGT_ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [VW-1:0]   DIV3_M  = VW'(((1 << DIV3_SH) + 2) / 3);
  localparam logic [ACCW-1:0] INNER_BIAS =
    (ACCW'(4) << (3 * FRAC_BITS)) + (ACCW'(3) << (2 * FRAC_BITS));

  typedef enum logic [ORDER_W-1:0] {
    ORD_NEAREST = 2'd0,
    ORD_LINEAR  = 2'd1,
    ORD_QUAD    = 2'd2,
    ORD_CUBIC   = 2'd3
  } order_t;

  typedef logic [LANES-1:0][WW-1:0] wgt_vec_t;

endpackage

/* src/bspline_weight_generator_top.sv */
// Channel | Dir | tdata fields (low bit up)                          | Handshake
// in_     | in  | frac_pos [15:0], pad to 16                          | tvalid/tready
// out_    | out | weight_0 [16:0], weight_1, weight_2, weight_3, pad  | tvalid/tready
// cfg_    | in  | bsp_order [1:0]                                    | valid/ready
//
// Six register stages: a word accepted on in_ passes stages 1 to 5 and the output
// register in turn before it shows on out_ with out_tvalid high.
// One word is taken per cycle while out_tready stays high. The depth is set by two
// chained multiplies (square, cube), the cubic sum and the reciprocal divide by six.
// rst_n (synchronous) clears all valid bits and sets the order to cubic.
// While a result waits on out_ unclaimed, every stage holds and in_tready is low.
module bspline_weight_generator_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [bswg_pkg::IN_TDATA_W-1:0]      in_tdata,   // frac_pos
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [bswg_pkg::OUT_TDATA_W-1:0]     out_tdata,  // weight_0..weight_3, zero pad
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bswg_pkg::ORDER_W-1:0]         cfg_data    // bsp_order
);

  localparam int FB    = bswg_pkg::FRAC_BITS;
  localparam int XW    = bswg_pkg::XW;
  localparam int WW    = bswg_pkg::WW;
  localparam int X2W   = bswg_pkg::X2W;
  localparam int T2W   = bswg_pkg::T2W;
  localparam int X3W   = bswg_pkg::X3W;
  localparam int T3W   = bswg_pkg::T3W;
  localparam int ACCW  = bswg_pkg::ACCW;
  localparam int QW    = bswg_pkg::QW;
  localparam int PW    = bswg_pkg::PW;
  localparam int LANES = bswg_pkg::LANES;

  logic en;

  bswg_pkg::order_t order_r;

  // stage 1
  logic               v1_r;
  logic [XW-1:0]      x1_r;
  logic [WW-1:0]      y1_r;
  bswg_pkg::order_t   ord1_r;
  logic [WW-1:0]      y1_nxt;

  // stage 2
  logic               v2_r;
  logic [XW-1:0]      x2_r;
  logic [WW-1:0]      y2_r;
  logic [X2W-1:0]     xx2_r;
  logic [T2W-1:0]     yy2_r;
  logic [T2W-1:0]     dd2_r;
  bswg_pkg::order_t   ord2_r;
  logic [X2W-1:0]     xx2_nxt;
  logic [T2W-1:0]     yy2_nxt;
  logic [T2W-1:0]     dd2_nxt;
  logic [WW-1:0]      two_x;
  logic [WW-1:0]      mid_dev;

  // stage 3
  logic               v3_r;
  logic [X2W-1:0]     xx3_r;
  logic [T2W-1:0]     yy3_r;
  logic [X3W-1:0]     xxx3_r;
  logic [T3W-1:0]     yyy3_r;
  bswg_pkg::wgt_vec_t wa3_r;
  bswg_pkg::order_t   ord3_r;
  logic [X3W-1:0]     xxx3_nxt;
  logic [T3W-1:0]     yyy3_nxt;
  bswg_pkg::wgt_vec_t wa3_nxt;
  logic [T2W+1:0]     q2_mid;
  logic [T2W:0]       q2_x;
  logic [T2W:0]       q2_y;

  // stage 4
  logic                        v4_r;
  logic [LANES-1:0][QW-1:0]    q4_r;
  bswg_pkg::wgt_vec_t          wa4_r;
  bswg_pkg::order_t            ord4_r;
  logic [LANES-1:0][QW-1:0]    q4_nxt;
  logic [ACCW-1:0]             acc_x;
  logic [ACCW-1:0]             acc_y;

  // stage 5
  logic                        v5_r;
  logic [LANES-1:0][PW-1:0]    p5_r;
  bswg_pkg::wgt_vec_t          wa5_r;
  bswg_pkg::order_t            ord5_r;
  logic [LANES-1:0][PW-1:0]    p5_nxt;

  // output stage
  logic                        out_tvalid_r;
  logic [bswg_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic [bswg_pkg::OUT_TDATA_W-1:0] out_tdata_nxt;
  bswg_pkg::wgt_vec_t          wcub;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= bswg_pkg::ORD_CUBIC;
    end else if (cfg_valid) begin
      order_r <= bswg_pkg::order_t'(cfg_data);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      v5_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      v1_r         <= in_tvalid;
      v2_r         <= v1_r;
      v3_r         <= v2_r;
      v4_r         <= v3_r;
      v5_r         <= v4_r;
      out_tvalid_r <= v5_r;
    end
  end

  // stage 1: capture x, form 1-x
  assign y1_nxt = bswg_pkg::WGT_ONE - WW'(in_tdata[XW-1:0]);

  // stage 2: squares and (2x-1)^2
  always_comb begin
    two_x   = {x1_r, 1'b0};
    mid_dev = (two_x >= bswg_pkg::WGT_ONE) ? (two_x - bswg_pkg::WGT_ONE)
                                           : (bswg_pkg::WGT_ONE - two_x);
    xx2_nxt = X2W'(x1_r) * X2W'(x1_r);
    yy2_nxt = T2W'(y1_r) * T2W'(y1_r);
    dd2_nxt = T2W'(mid_dev) * T2W'(mid_dev);
  end

  // stage 3: cubes; weights of orders 0..2 are final here
  always_comb begin
    xxx3_nxt = X3W'(xx2_r) * X3W'(x2_r);
    yyy3_nxt = T3W'(yy2_r) * T3W'(y2_r);
    // 3/4 - (x-1/2)^2 with rounding: (3 S^2 + 2S - d^2) >> (F+2)
    q2_mid   = (T2W+2)'(3) * ((T2W+2)'(1) << (2 * FB))
             + ((T2W+2)'(1) << (FB + 1)) - (T2W+2)'(dd2_r);
    q2_x     = (T2W+1)'(xx2_r) + ((T2W+1)'(1) << FB);
    q2_y     = (T2W+1)'(yy2_r) + ((T2W+1)'(1) << FB);
    wa3_nxt  = '0;
    unique case (ord2_r)
      bswg_pkg::ORD_NEAREST: begin
        wa3_nxt[0] = bswg_pkg::WGT_ONE;
      end
      bswg_pkg::ORD_LINEAR: begin
        wa3_nxt[0] = y2_r;
        wa3_nxt[1] = WW'(x2_r);
      end
      bswg_pkg::ORD_QUAD: begin
        wa3_nxt[0] = WW'(q2_y >> (FB + 1));
        wa3_nxt[1] = WW'(q2_mid >> (FB + 2));
        wa3_nxt[2] = WW'(q2_x >> (FB + 1));
      end
      bswg_pkg::ORD_CUBIC: begin
        wa3_nxt = '0;
      end
      default: begin
        wa3_nxt = '0;
      end
    endcase
  end

  // stage 4: cubic numerators over 2^2F, bias for round-to-nearest included
  always_comb begin
    // 4S^3 + 3S^2 + 3t^3 - 6 t^2 S, never negative on [0,1]
    acc_x = bswg_pkg::INNER_BIAS + ACCW'(xxx3_r) + (ACCW'(xxx3_r) << 1)
          - ((ACCW'(xx3_r) + (ACCW'(xx3_r) << 1)) << (FB + 1));
    acc_y = bswg_pkg::INNER_BIAS + ACCW'(yyy3_r) + (ACCW'(yyy3_r) << 1)
          - ((ACCW'(yy3_r) + (ACCW'(yy3_r) << 1)) << (FB + 1));
    q4_nxt[0] = QW'(yyy3_r >> (2 * FB)) + QW'(3);
    q4_nxt[1] = QW'(acc_x >> (2 * FB));
    q4_nxt[2] = QW'(acc_y >> (2 * FB));
    q4_nxt[3] = QW'(xxx3_r >> (2 * FB)) + QW'(3);
  end

  // stage 5: q/6 = (q>>1)/3 by reciprocal multiply
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      p5_nxt[i] = PW'(q4_r[i][QW-1:1]) * PW'(bswg_pkg::DIV3_M);
    end
  end

  // output stage
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      wcub[i] = WW'(p5_r[i] >> bswg_pkg::DIV3_SH);
    end
    if (ord5_r == bswg_pkg::ORD_CUBIC) begin
      out_tdata_nxt = bswg_pkg::OUT_TDATA_W'(wcub);
    end else begin
      out_tdata_nxt = bswg_pkg::OUT_TDATA_W'(wa5_r);
    end
  end

  // payload, held while stalled
  always_ff @(posedge clk) begin
    if (en) begin
      x1_r        <= in_tdata[XW-1:0];
      y1_r        <= y1_nxt;
      ord1_r      <= order_r;

      x2_r        <= x1_r;
      y2_r        <= y1_r;
      xx2_r       <= xx2_nxt;
      yy2_r       <= yy2_nxt;
      dd2_r       <= dd2_nxt;
      ord2_r      <= ord1_r;

      xx3_r       <= xx2_r;
      yy3_r       <= yy2_r;
      xxx3_r      <= xxx3_nxt;
      yyy3_r      <= yyy3_nxt;
      wa3_r       <= wa3_nxt;
      ord3_r      <= ord2_r;

      q4_r        <= q4_nxt;
      wa4_r       <= wa3_r;
      ord4_r      <= ord3_r;

      p5_r        <= p5_nxt;
      wa5_r       <= wa4_r;
      ord5_r      <= ord4_r;

      out_tdata_r <= out_tdata_nxt;
    end
  end

endmodule

/* src/bswg_chk.sv */
`include "bspline_weight_generator_top_assert.svh"

module bswg_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [bswg_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int WW = bswg_pkg::WW;

  logic w_ok;

  // first weight is at most one, pad bits stay clear
  assign w_ok = (out_tdata[WW-1:0] <= bswg_pkg::WGT_ONE)
             && ((out_tdata >> (bswg_pkg::LANES * WW)) == '0);

  // a word left on out_ must wait unchanged
  `BSWG_AST_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // nothing waits on out_, so the pipeline must be taking input
  `BSWG_AST_IMPL(a_in_ready_free, !out_tvalid, in_tready)

  `BSWG_AST_IMPL(a_w0_range, out_tvalid, w_ok)

  `BSWG_AST_RST(a_rst_empty, !out_tvalid)

endmodule

bind bspline_weight_generator_top bswg_chk u_bswg_chk (.*);

/* dv/bswg_weight_checker.sv */
module bswg_weight_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [bswg_pkg::IN_TDATA_W-1:0]  in_tdata,    // frac_pos
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [bswg_pkg::OUT_TDATA_W-1:0] out_tdata,   // weight_0..weight_3, zero pad
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [bswg_pkg::ORDER_W-1:0]     cfg_data,    // bsp_order
  output int                               fail_count,
  output int                               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int F     = bswg_pkg::FRAC_BITS;
  localparam int XW    = bswg_pkg::XW;
  localparam int WW    = bswg_pkg::WW;
  localparam int LANES = bswg_pkg::LANES;
  localparam longint unsigned ONE  = 64'd1 << F;
  localparam longint unsigned MASK = ONE - 64'd1;

  typedef struct {
    bswg_pkg::order_t   ord;
    logic [XW-1:0]      pos;
    bswg_pkg::wgt_vec_t w;
  } weight_set_t;

  weight_set_t      weight_q[$];
  bswg_pkg::order_t cur_order;
  int               errs;

  assign fail_count = errs;

  // y^3 = hi * 2^2F + lo
  function automatic void cube_split(input longint unsigned y,
                                     output longint unsigned hi,
                                     output longint unsigned lo);
    longint unsigned a, m, v;
    a  = y * y;
    m  = (a & MASK) * y;
    v  = (a >> F) * y + (m >> F);
    hi = v >> F;
    lo = ((v & MASK) << F) + (m & MASK);
  endfunction

  function automatic logic [WW-1:0] outer_wgt(input longint unsigned y);
    longint unsigned hi, lo;
    cube_split(y, hi, lo);
    return WW'((hi + 64'd3) / 64'd6);
  endfunction

  // round((4 S^3 - 6 y^2 S + 3 y^3) / 6 S^2), with the fraction folded in exactly
  function automatic logic [WW-1:0] inner_wgt(input longint unsigned y);
    longint unsigned a, p1, p0, m, r, q;
    a = y * y;
    cube_split(y, p1, p0);
    m = 64'd4 * ONE + 64'd3 * p1 - 64'd6 * (a >> F);
    r = 64'd3 * p0 + 64'd6 * (ONE * ONE) - 64'd6 * ((a & MASK) * ONE);
    q = m + (r >> (2 * F)) - 64'd6;
    return WW'((q + 64'd3) / 64'd6);
  endfunction

  function automatic bswg_pkg::wgt_vec_t bspline_weights(input bswg_pkg::order_t ord,
                                                         input logic [XW-1:0] pos);
    longint unsigned x, y, d;
    bswg_pkg::wgt_vec_t w;
    x = pos;
    y = ONE - x;
    w = '0;
    case (ord)
      bswg_pkg::ORD_NEAREST: w[0] = bswg_pkg::WGT_ONE;
      bswg_pkg::ORD_LINEAR: begin
        w[0] = WW'(y);
        w[1] = WW'(x);
      end
      bswg_pkg::ORD_QUAD: begin
        d    = (2 * x >= ONE) ? (2 * x - ONE) : (ONE - 2 * x);
        w[0] = WW'((y * y + ONE) >> (F + 1));
        w[1] = WW'((64'd3 * (ONE * ONE) - d * d + 64'd2 * ONE) >> (F + 2));
        w[2] = WW'((x * x + ONE) >> (F + 1));
      end
      default: begin
        w[0] = outer_wgt(y);
        w[1] = inner_wgt(x);
        w[2] = inner_wgt(y);
        w[3] = outer_wgt(x);
      end
    endcase
    return w;
  endfunction

  initial begin
    errs        = 0;
    outstanding = 0;
    cur_order   = bswg_pkg::ORD_CUBIC;
  end

  always @(posedge clk) begin
    weight_set_t        ws;
    bswg_pkg::wgt_vec_t got;
    if (!rst_n) begin
      cur_order = bswg_pkg::ORD_CUBIC;
      weight_q.delete();
    end else begin
      // pop before push: a word taken this edge can't be the one leaving
      if (out_tvalid && out_tready) begin
        got = out_tdata[LANES*WW-1:0];
        if (weight_q.size() == 0) begin
          $error("result word with nothing pending: %h", got);
          errs++;
        end else begin
          ws = weight_q.pop_front();
          for (int i = 0; i < LANES; i++) begin
            if (got[i] !== ws.w[i]) begin
              $error("weight_%0d expected %0d actual %0d (order %s, frac_pos %0d)",
                     i, ws.w[i], got[i], ws.ord.name(), ws.pos);
              errs++;
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        ws.ord = cur_order;
        ws.pos = in_tdata[XW-1:0];
        ws.w   = bspline_weights(cur_order, in_tdata[XW-1:0]);
        weight_q.push_back(ws);
      end
      if (cfg_valid && cfg_ready)
        cur_order = bswg_pkg::order_t'(cfg_data);
    end
    outstanding <= weight_q.size();
  end

endmodule

/* dv/bspline_weight_generator_top_tb.sv */
module bspline_weight_generator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int XW         = bswg_pkg::XW;
  localparam int PHASES     = 10;
  localparam int PHASE_LEN  = 190;
  localparam int STALL_MAX  = 10;
  localparam int IDLE_LIMIT = 2000;

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [bswg_pkg::IN_TDATA_W-1:0]  in_tdata;    // frac_pos
  logic                             out_tvalid;
  logic                             out_tready;
  logic [bswg_pkg::OUT_TDATA_W-1:0] out_tdata;   // weight_0..weight_3, zero pad
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [bswg_pkg::ORDER_W-1:0]     cfg_data;    // bsp_order

  int               fail_count;
  int               outstanding;
  int               idle_cycles;
  int               pos_per_order[4];
  int               order_writes;
  bit               in_free;
  bit               out_free;
  bswg_pkg::order_t drv_order;

  bspline_weight_generator_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  bswg_weight_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog: nothing moving on any channel for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", idle_cycles);
      $display("[bspline_weight_generator_top] ERROR");
      $finish;
    end
  end

  // result sink with random back-pressure
  initial begin : sink
    int stall;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = out_free ? 0 : $urandom_range(0, STALL_MAX);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_pos(input logic [XW-1:0] pos);
    int gap;
    gap = in_free ? 0 : $urandom_range(0, STALL_MAX);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= bswg_pkg::IN_TDATA_W'(pos);
    do @(posedge clk); while (!in_tready);
    pos_per_order[drv_order]++;
  endtask

  // the pending count is a registered copy of the queue size, so it updates in the cycle after a word is accepted
  task automatic drain_weights();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_order(input bswg_pkg::order_t ord);
    drain_weights();
    cfg_valid <= 1'b1;
    cfg_data  <= ord;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    drv_order = ord;
    order_writes++;
  endtask

  function automatic logic [XW-1:0] rand_pos();
    case ($urandom_range(0, 7))
      0:       return XW'($urandom_range(0, 15));
      1:       return XW'(16'hFFFF - $urandom_range(0, 15));
      2:       return XW'(16'h8000 + $urandom_range(0, 32) - 16);
      default: return XW'($urandom);
    endcase
  endfunction

  initial begin
    bswg_pkg::order_t ph_order;
    idle_cycles  = 0;
    order_writes = 0;
    in_free      = 1'b0;
    out_free     = 1'b0;
    drv_order    = bswg_pkg::ORD_CUBIC;
    foreach (pos_per_order[i]) pos_per_order[i] = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset order is cubic, then each order at the interval edges, all but nearest also at the midpoint
    send_pos(16'h0000); send_pos(16'h0001); send_pos(16'h7FFF);
    send_pos(16'h8000); send_pos(16'hFFFF); send_pos(16'h5555);
    write_order(bswg_pkg::ORD_NEAREST);
    send_pos(16'h0000); send_pos(16'hFFFF);
    write_order(bswg_pkg::ORD_LINEAR);
    send_pos(16'h0000); send_pos(16'h8000); send_pos(16'hFFFF);
    write_order(bswg_pkg::ORD_QUAD);
    send_pos(16'h0000); send_pos(16'h0001); send_pos(16'h7FFF);
    send_pos(16'h8000); send_pos(16'hFFFF);
    write_order(bswg_pkg::ORD_CUBIC);
    send_pos(16'hAAAA); send_pos(16'h0002);

    // random phases, first four sweep every order including both extremes
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       ph_order = bswg_pkg::ORD_NEAREST;
        1:       ph_order = bswg_pkg::ORD_CUBIC;
        2:       ph_order = bswg_pkg::ORD_LINEAR;
        3:       ph_order = bswg_pkg::ORD_QUAD;
        default: ph_order = bswg_pkg::order_t'($urandom_range(0, 3));
      endcase
      write_order(ph_order);
      in_free  = ($urandom_range(0, 3) == 0);
      out_free = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_LEN; i++) begin
        if (ph == 5 && i == PHASE_LEN / 2)
          drain_weights();
        send_pos(rand_pos());
      end
    end
    in_free  = 1'b0;
    out_free = 1'b0;

    drain_weights();
    repeat (12) @(posedge clk);

    $display("Sent %0d positions: nearest %0d, linear %0d, quadratic %0d, cubic %0d",
             pos_per_order[0] + pos_per_order[1] + pos_per_order[2] + pos_per_order[3],
             pos_per_order[bswg_pkg::ORD_NEAREST], pos_per_order[bswg_pkg::ORD_LINEAR],
             pos_per_order[bswg_pkg::ORD_QUAD], pos_per_order[bswg_pkg::ORD_CUBIC]);
    $display("Order register written %0d times; %0d mismatches", order_writes, fail_count);
    if (fail_count == 0 && outstanding == 0)
      $display("[bspline_weight_generator_top] OK");
    else
      $display("[bspline_weight_generator_top] ERROR");
    $finish;
  end

endmodule
